// File: rtl/tone_burst_generator_defines.svh
// Assertion macros used by the tone burst generator top level.
`ifndef TONE_BURST_GENERATOR_DEFINES_SVH
`define TONE_BURST_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TBG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tbg_pkg.sv
// Shared types, widths and constants of the tone burst generator.
package tbg_pkg;

  localparam int TIME_BITS   = 32;
  localparam int NOW_W       = 32;
  localparam int FREQ_W      = 15;
  localparam int DUR_W       = 16;
  localparam int HALF_W      = 20;
  localparam int EDGES_W     = 23;
  localparam int MUL_W       = 16;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int MUL_CNT_W   = $clog2(MUL_W);
  localparam int DIV_W       = 32;
  localparam int DVSR_W      = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [HALF_W-1:0]    half_t;
  typedef logic [EDGES_W-1:0]   edges_t;
  typedef logic [MUL_W-1:0]     mul_op_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [DIV_W-1:0]     div_word_t;
  typedef logic [DVSR_W-1:0]    dvsr_t;

  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  localparam div_word_t US_PER_S  = div_word_t'(1000000);
  localparam dvsr_t     MS_PER_S  = dvsr_t'(1000);
  localparam half_t     MIN_HALF  = half_t'(1);
  localparam edges_t    MIN_EDGES = edges_t'(2);

endpackage

// File: rtl/tbg_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module tbg_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tbg_pkg::prod_t  mcand,
  input  tbg_pkg::mul_op_t mplier,
  output logic            busy,
  output tbg_pkg::prod_t  product
);

  tbg_pkg::prod_t                  mcand_r, mcand_nxt;
  tbg_pkg::mul_op_t                mplier_r, mplier_nxt;
  tbg_pkg::prod_t                  acc_r, acc_nxt;
  logic [tbg_pkg::MUL_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;

  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    if (start && !busy_r) begin
      mcand_nxt  = mcand;
      mplier_nxt = mplier;
      acc_nxt    = '0;
      cnt_nxt    = '1;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[tbg_pkg::PROD_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[tbg_pkg::MUL_W-1:1]};
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign busy    = busy_r;
  assign product = acc_r;

endmodule

// File: rtl/tbg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tbg_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tbg_pkg::div_word_t  dividend,
  input  tbg_pkg::dvsr_t      divisor,
  output logic                busy,
  output logic                done,
  output tbg_pkg::div_word_t  quotient
);

  tbg_pkg::div_word_t             quo_r, quo_nxt;
  tbg_pkg::dvsr_t                 rem_r, rem_nxt;
  tbg_pkg::dvsr_t                 dvsr_r, dvsr_nxt;
  logic [tbg_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [tbg_pkg::DVSR_W:0]       trial;
  logic [tbg_pkg::DVSR_W:0]       diff;
  logic                           fits;

  // The dividend shifts out of the top of quo_r while quotient bits enter at the bottom.
  assign trial = {rem_r, quo_r[tbg_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvsr_r};
  assign fits  = (trial >= {1'b0, dvsr_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
      cnt_nxt  = '1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[tbg_pkg::DVSR_W-1:0] : trial[tbg_pkg::DVSR_W-1:0];
      quo_nxt = {quo_r[tbg_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/tone_burst_generator.sv
// Top level of the square-wave tone burst generator.
//
// Input channel (in_*): one request per handshake. in_tuser selects the kind:
// a tone request carries frequency and duration, a service tick carries the
// current microsecond time. Every request yields exactly one result on the
// out_* channel with the buzzer level and a busy flag after that request.
// A tone request computes the half period 1000000 / (2 f) and the edge count
// d * 2 f / 1000 with a bit-serial divider of 32 steps, used twice in a row;
// the product d * 2 f is formed by a bit-serial multiplier of 16 steps that
// runs during the first division. A tone request with zero frequency or
// duration goes straight to the result hand-off. A service tick passes
// through three single-step timing stages and the result hand-off, and
// skips the third when the second timing stage finds no burst running or
// ends the burst itself.
// One request is in work at a time; the result register frees the input as
// soon as it is loaded, so the next request can be accepted while a result
// still waits. When the receiver stalls with a result waiting, a finished
// request holds in its last state until the result register drains.
// Reset clears the burst, the pending request and the result channel.
module tone_burst_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata, from bit 0: tone_freq[14:0], duration_ms[30:15], now_us[62:31], zero pad.
  input  logic [tbg_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: func (0 = tone request, 1 = service tick).
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata, from bit 0: tone_out, busy_res, zero pad.
  output logic [tbg_pkg::OUT_TDATA_W-1:0]     out_tdata
);

`include "tone_burst_generator_defines.svh"

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DIV1      = 3'd1;
  localparam logic [2:0] S_DIV2      = 3'd2;
  localparam logic [2:0] S_SVC_START = 3'd3;
  localparam logic [2:0] S_SVC_EDGE  = 3'd4;
  localparam logic [2:0] S_SVC_END   = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  // Input fields.
  logic [tbg_pkg::FREQ_W-1:0] tone_freq;
  logic [tbg_pkg::DUR_W-1:0]  duration_ms;
  logic [tbg_pkg::NOW_W-1:0]  now_us;
  tbg_pkg::mul_op_t           twice_freq;
  logic                       in_fire;
  logic                       req_ok;

  assign tone_freq    = in_tdata[14:0];
  assign duration_ms  = in_tdata[30:15];
  assign now_us       = in_tdata[62:31];
  assign twice_freq   = {tone_freq, 1'b0};
  assign in_fire      = in_tvalid && in_tready;
  assign req_ok       = (tone_freq != '0) && (duration_ms != '0);

  // Control and burst state.
  logic [2:0]          state_r, state_nxt;
  logic                burst_active_r, burst_active_nxt;
  logic                start_pending_r, start_pending_nxt;
  logic                level_high_r, level_high_nxt;
  tbg_pkg::edges_t     edges_left_r, edges_left_nxt;
  tbg_pkg::time_t      next_edge_r, next_edge_nxt;
  tbg_pkg::half_t      run_half_r, run_half_nxt;
  tbg_pkg::half_t      queued_half_r, queued_half_nxt;
  tbg_pkg::edges_t     queued_edges_r, queued_edges_nxt;
  tbg_pkg::time_t      now_r, now_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_data_r, out_data_nxt;

  // Arithmetic units.
  logic                mul_start;
  logic                mul_busy;
  tbg_pkg::prod_t      mul_prod;
  logic                div_start;
  tbg_pkg::div_word_t  div_dividend;
  tbg_pkg::dvsr_t      div_divisor;
  logic                div_busy;
  logic                div_done;
  tbg_pkg::div_word_t  div_quo;

  tbg_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (tbg_pkg::prod_t'(duration_ms)),
    .mplier  (twice_freq),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  tbg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Wrap-safe time compare: an edge is due when now - next is not negative.
  tbg_pkg::time_t time_diff;
  logic           edge_due;

  assign time_diff = now_r - next_edge_r;
  assign edge_due  = !time_diff[tbg_pkg::TIME_BITS-1];

  // The first division runs on the request fields, the second on the product.
  always_comb begin
    mul_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = tbg_pkg::US_PER_S;
    div_divisor  = twice_freq;
    if (state_r == S_IDLE) begin
      mul_start = in_fire && (in_tuser == tbg_pkg::FUNC_REQUEST) && req_ok;
      div_start = mul_start;
    end else if (state_r == S_DIV1) begin
      div_dividend = mul_prod;
      div_divisor  = tbg_pkg::MS_PER_S;
      div_start    = div_done;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    burst_active_nxt  = burst_active_r;
    start_pending_nxt = start_pending_r;
    level_high_nxt    = level_high_r;
    edges_left_nxt    = edges_left_r;
    next_edge_nxt     = next_edge_r;
    run_half_nxt      = run_half_r;
    queued_half_nxt   = queued_half_r;
    queued_edges_nxt  = queued_edges_r;
    now_nxt           = now_r;
    out_data_nxt      = out_data_r;
    out_valid_nxt     = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          now_nxt = tbg_pkg::time_t'(now_us);
          if (in_tuser == tbg_pkg::FUNC_SERVICE) begin
            state_nxt = S_SVC_START;
          end else if (req_ok) begin
            state_nxt = S_DIV1;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV1: begin
        if (div_done) begin
          queued_half_nxt = (div_quo == '0) ? tbg_pkg::MIN_HALF
                                            : div_quo[tbg_pkg::HALF_W-1:0];
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          queued_edges_nxt  = (div_quo < tbg_pkg::div_word_t'(tbg_pkg::MIN_EDGES))
                              ? tbg_pkg::MIN_EDGES : div_quo[tbg_pkg::EDGES_W-1:0];
          start_pending_nxt = 1'b1;
          state_nxt         = S_OUT;
        end
      end
      S_SVC_START: begin
        // A pending request restarts the burst from the current time.
        if (start_pending_r) begin
          start_pending_nxt = 1'b0;
          burst_active_nxt  = 1'b1;
          level_high_nxt    = 1'b1;
          run_half_nxt      = queued_half_r;
          edges_left_nxt    = queued_edges_r - tbg_pkg::edges_t'(1);
          next_edge_nxt     = now_r + tbg_pkg::time_t'(queued_half_r);
        end
        state_nxt = S_SVC_EDGE;
      end
      S_SVC_EDGE: begin
        if (!burst_active_r) begin
          state_nxt = S_OUT;
        end else if (edge_due && (edges_left_r == '0)) begin
          burst_active_nxt = 1'b0;
          level_high_nxt   = 1'b0;
          edges_left_nxt   = '0;
          next_edge_nxt    = '0;
          run_half_nxt     = '0;
          queued_half_nxt  = '0;
          queued_edges_nxt = '0;
          state_nxt        = S_OUT;
        end else begin
          if (edge_due) begin
            level_high_nxt = !level_high_r;
            edges_left_nxt = edges_left_r - tbg_pkg::edges_t'(1);
            next_edge_nxt  = next_edge_r + tbg_pkg::time_t'(run_half_r);
          end
          state_nxt = S_SVC_END;
        end
      end
      S_SVC_END: begin
        // The last edge may already be due against the advanced edge time.
        if (edge_due && (edges_left_r == '0)) begin
          burst_active_nxt = 1'b0;
          level_high_nxt   = 1'b0;
          edges_left_nxt   = '0;
          next_edge_nxt    = '0;
          run_half_nxt     = '0;
          queued_half_nxt  = '0;
          queued_edges_nxt = '0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {start_pending_r || burst_active_r, level_high_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      burst_active_r  <= 1'b0;
      start_pending_r <= 1'b0;
      level_high_r    <= 1'b0;
      edges_left_r    <= '0;
      next_edge_r     <= '0;
      run_half_r      <= '0;
      queued_half_r   <= '0;
      queued_edges_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      burst_active_r  <= burst_active_nxt;
      start_pending_r <= start_pending_nxt;
      level_high_r    <= level_high_nxt;
      edges_left_r    <= edges_left_nxt;
      next_edge_r     <= next_edge_nxt;
      run_half_r      <= run_half_nxt;
      queued_half_r   <= queued_half_nxt;
      queued_edges_r  <= queued_edges_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    now_r      <= now_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tbg_pkg::OUT_TDATA_W-2){1'b0}}, out_data_r};

  // The buzzer is only ever driven high inside a burst.
  `TBG_ASSERT_IMP(a_level_needs_burst, !burst_active_r, !level_high_r,
                  "buzzer level high without an active burst")
  // A pending request always carries usable timing values.
  `TBG_ASSERT_IMP(a_pending_values, start_pending_r,
                  (queued_edges_r >= tbg_pkg::MIN_EDGES) && (queued_half_r != '0),
                  "pending request with zero half period or too few edges")
  // The product must be complete before the second division reads it.
  `TBG_ASSERT_IMP(a_mul_before_div2, (state_r == S_DIV1) && div_done, !mul_busy,
                  "second division started before the multiplier finished")
  // Loading a result frees the input side in the next cycle.
  `TBG_ASSERT_NXT(a_out_load, (state_r == S_OUT) && (!out_valid_r || out_tready),
                  out_tvalid && in_tready && !div_busy,
                  "result load did not present a result and reopen the input")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the square-wave tone burst generator.
`timescale 1ns / 1ps

module testbench;
  import tbg_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int MAX_GAP      = 18;
  // Requests counted in the random part; ignored tone requests do not count.
  localparam int RANDOM_COUNT = 1200;
  // Covers a valid tone request plus the longest idle gap of either side.
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 10;

  localparam logic [31:0] US_PER_SECOND = 32'd1000000;
  localparam logic [31:0] MS_PER_SECOND = 32'd1000;

  // One result as it leaves the block: level first, then busy.
  typedef struct packed {
    logic tone;
    logic busy;
  } level_t;

  // One row of the directed table. Rows with known_result set carry the
  // result that is expected; all other rows are checked against the predictor.
  typedef struct packed {
    logic        func;
    logic [14:0] freq;
    logic [15:0] dur;
    logic [31:0] now;
    bit          known_result;
    logic        want_tone;
    logic        want_busy;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Service while idle with nothing pending leaves everything low.
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'h0000_0000, 1'b1, 1'b0, 1'b0},
    // Zero frequency and zero duration are both ignored.
    '{FUNC_REQUEST, 15'd0,     16'd5,     32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
    '{FUNC_REQUEST, 15'd5,     16'd0,     32'h0000_0000, 1'b1, 1'b0, 1'b0},
    // Largest frequency and duration: pending, level still low.
    '{FUNC_REQUEST, 15'd32767, 16'd65535, 32'hA5A5_A5A5, 1'b1, 1'b0, 1'b1},
    // The newest pending request replaces the earlier one; edge count floors at two.
    '{FUNC_REQUEST, 15'd1,     16'd1,     32'h0000_0000, 1'b1, 1'b0, 1'b1},
    // Start at the top of the time range; the first edge lands after the wrap.
    '{FUNC_SERVICE, 15'h7FFF,  16'hFFFF,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'd499998,    1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'd499999,    1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'd999999,    1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'h1234_5678, 1'b1, 1'b0, 1'b0},
    // A burst that is replaced while it runs restarts on the next service.
    '{FUNC_REQUEST, 15'd32767, 16'd1,     32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{FUNC_REQUEST, 15'd1000,  16'd1,     32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'd5,         1'b0, 1'b0, 1'b0},
    // Exactly half the time range behind is not due, one less is due.
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'h8000_01F9, 1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'h8000_01F8, 1'b0, 1'b0, 1'b0},
    // Late service: the last edge toggles and the burst stops on the same tick.
    '{FUNC_REQUEST, 15'd1000,  16'd1,     32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'd2000,      1'b0, 1'b0, 1'b0},
    // Long burst; an ignored request while it runs still reports busy.
    '{FUNC_REQUEST, 15'd16384, 16'd65535, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'd0,     16'd0,     32'h7FFF_FFF0, 1'b0, 1'b0, 1'b0},
    '{FUNC_REQUEST, 15'd0,     16'd0,     32'h5555_5555, 1'b0, 1'b0, 1'b0},
    '{FUNC_SERVICE, 15'h2AAA,  16'h5555,  32'h8000_000E, 1'b0, 1'b0, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  tone_burst_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: a copy of the burst generator's registers.
  logic               pr_active;
  logic               pr_pending;
  logic               pr_level;
  logic [EDGES_W-1:0] pr_edges_left;
  logic [31:0]        pr_next_edge;
  logic [HALF_W-1:0]  pr_run_half;
  logic [HALF_W-1:0]  pr_q_half;
  logic [EDGES_W-1:0] pr_q_edges;

  // Levels that the block still owes, oldest first.
  level_t pending_levels [$];

  int          mismatches  = 0;
  int          live_count  = 0;
  int          sent_count  = 0;
  int          recv_count  = 0;
  int          idle_cycles = 0;
  logic [31:0] clock_us;

  function automatic void clear_tone_state();
    pr_active     = 1'b0;
    pr_pending    = 1'b0;
    pr_level      = 1'b0;
    pr_edges_left = '0;
    pr_next_edge  = '0;
    pr_run_half   = '0;
    pr_q_half     = '0;
    pr_q_edges    = '0;
  endfunction

  // Due means the wrap-safe difference now - next edge is not negative.
  function automatic logic toggle_due(logic [31:0] now);
    logic [31:0] diff;
    diff = now - pr_next_edge;
    return !diff[31];
  endfunction

  // Applies one request to the predictor and returns the level after it.
  function automatic level_t next_tone_level(logic func, logic [14:0] freq,
                                             logic [15:0] dur, logic [31:0] now);
    logic [31:0] twice;
    logic [31:0] half;
    logic [31:0] count;
    level_t      res;
    if (func == FUNC_REQUEST) begin
      if (freq != 0 && dur != 0) begin
        twice = {16'd0, freq, 1'b0};
        half  = US_PER_SECOND / twice;
        if (half == 0) half = 1;
        count = ({16'd0, dur} * twice) / MS_PER_SECOND;
        if (count < 2) count = 2;
        pr_q_half  = half[HALF_W-1:0];
        pr_q_edges = count[EDGES_W-1:0];
        pr_pending = 1'b1;
      end
    end else begin
      if (pr_pending) begin
        pr_pending    = 1'b0;
        pr_active     = 1'b1;
        pr_level      = 1'b1;
        pr_run_half   = pr_q_half;
        pr_edges_left = pr_q_edges - 1'b1;
        pr_next_edge  = now + {12'd0, pr_run_half};
      end
      if (pr_active) begin
        if (toggle_due(now)) begin
          if (pr_edges_left == 0) begin
            pr_active = 1'b0;
          end else begin
            pr_level      = !pr_level;
            pr_edges_left = pr_edges_left - 1'b1;
            pr_next_edge  = pr_next_edge + {12'd0, pr_run_half};
          end
        end
        // A service far past the last toggle also ends the burst.
        if (pr_active && pr_edges_left == 0 && toggle_due(now)) pr_active = 1'b0;
        if (!pr_active) clear_tone_state();
      end
    end
    res.tone = pr_level;
    res.busy = pr_pending || pr_active;
    return res;
  endfunction

  // Idle cycles before the next request or result. Every fourth stretch of
  // 128 transfers runs back to back.
  function automatic int draw_gap(int n);
    if ((n / 128) % 4 == 3) return 0;
    return int'($urandom_range(0, MAX_GAP));
  endfunction

  // Presents one request and waits for its handshake. The expected level is
  // queued at the edge where the request is taken.
  task automatic send_request(input logic func, input logic [14:0] freq,
                              input logic [15:0] dur, input logic [31:0] now,
                              input bit known, input level_t known_level);
    int     gap;
    level_t pred;
    gap = draw_gap(sent_count);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {1'b0, now, dur, freq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = next_tone_level(func, freq, dur, now);
    pending_levels.push_back(known ? known_level : pred);
    sent_count++;
    if (!(func == FUNC_REQUEST && (freq == 0 || dur == 0))) live_count++;
  endtask

  task automatic send_random_request(input logic func, input logic [14:0] freq,
                                     input logic [15:0] dur, input logic [31:0] now);
    send_request(func, freq, dur, now, 1'b0, '0);
  endtask

  // Holds the sender off until the block has delivered everything it owes.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // A well-formed burst: a tone request followed by service ticks spaced
  // about one half period apart, with late, early and repeated ticks mixed in.
  task automatic run_burst();
    logic [14:0] freq;
    logic [15:0] dur;
    logic [31:0] half;
    int          dur_top;
    int          ticks;
    int          pick;
    freq = $urandom_range(0, 1) ? 15'($urandom_range(1, 32767))
                                : 15'($urandom_range(1, 2000));
    // Bounds the edge count by 24 + 2 f / 1000 so bursts end within the ticks.
    dur_top = 12000 / int'(freq) + 1;
    dur     = 16'($urandom_range(1, dur_top));
    half    = US_PER_SECOND / {16'd0, freq, 1'b0};
    pick    = $urandom_range(0, 7);
    if (pick == 0) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 2000000);
    else if (pick == 1) clock_us = $urandom();
    send_random_request(FUNC_REQUEST, freq, dur, $urandom());
    ticks = 0;
    do begin
      case ($urandom_range(0, 15))
        0: clock_us = clock_us;
        1: clock_us = clock_us + 2 * half + $urandom_range(0, 3);
        2: clock_us = clock_us - half;
        3: clock_us = clock_us + half - 1;
        default: clock_us = clock_us + half + $urandom_range(0, 4) - 2;
      endcase
      send_random_request(FUNC_SERVICE, 15'($urandom()), 16'($urandom()), clock_us);
      // Now and then a new tone arrives in the middle of the burst.
      if ($urandom_range(0, 29) == 0)
        send_random_request(FUNC_REQUEST, 15'($urandom_range(1, 4000)),
                            16'($urandom_range(1, 5)), $urandom());
      ticks++;
    end while ((pr_active || pr_pending) && ticks < 100);
  endtask

  // Unstructured requests over the full field ranges, zeros included.
  task automatic run_noise();
    logic [14:0] freq;
    logic [15:0] dur;
    int          n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      freq = ($urandom_range(0, 3) == 0) ? 15'd0 : 15'($urandom());
      dur  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
      send_random_request(logic'($urandom_range(0, 1)), freq, dur, $urandom());
    end
  endtask

  // A full-range tone followed by a few ticks at arbitrary times.
  task automatic run_wide_tone();
    send_random_request(FUNC_REQUEST, 15'($urandom_range(1, 32767)),
                        16'($urandom_range(1, 65535)), $urandom());
    repeat ($urandom_range(1, 4))
      send_random_request(FUNC_SERVICE, 15'($urandom()), 16'($urandom()), $urandom());
  endtask

  task automatic report_mismatch(input string field, input logic want, input logic got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("Mismatch on result %0d, %s: expected %0b, got %0b",
               recv_count, field, want, got);
  endtask

  // Sender: reset, the directed table, then the random sequences.
  initial begin
    level_t known_level;
    int     rand_base;
    bit     mid_drained;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= FUNC_REQUEST;
    in_tdata    <= '0;
    clear_tone_state();
    clock_us    = $urandom();
    mid_drained = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      known_level.tone = DIRECTED[i].want_tone;
      known_level.busy = DIRECTED[i].want_busy;
      send_request(DIRECTED[i].func, DIRECTED[i].freq, DIRECTED[i].dur,
                   DIRECTED[i].now, DIRECTED[i].known_result, known_level);
    end
    wait_all_results();

    rand_base = live_count;
    while (live_count - rand_base < RANDOM_COUNT) begin
      if (!mid_drained && live_count - rand_base >= RANDOM_COUNT / 2) begin
        wait_all_results();
        mid_drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        7:       run_noise();
        8:       run_wide_tone();
        default: run_burst();
      endcase
    end
    in_tvalid <= 1'b0;

    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: stalls at random, then checks each result against the oldest
  // level still owed.
  initial begin
    int     gap;
    level_t want;
    level_t got;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(recv_count + 64);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.tone = out_tdata[0];
      got.busy = out_tdata[1];
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result %0d: tone %0b busy %0b",
                   recv_count, got.tone, got.busy);
      end else begin
        want = pending_levels.pop_front();
        if (got.tone !== want.tone) report_mismatch("tone_out", want.tone, got.tone);
        if (got.busy !== want.busy) report_mismatch("busy_res", want.busy, got.busy);
      end
      recv_count++;
    end
  end

  // Watchdog: too many cycles in a row without any handshake ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
